/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the matrix store RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define RMMS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("matrix store assertion failed");
// Expression must never be true outside reset.
`define RMMS_ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("matrix store forbidden condition seen");
`else
`define RMMS_ASSERT(lbl, clk, rstn, prop)
`define RMMS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* sv/rmms_pkg.sv */
// ----------------------------------------------------------------------------
// rmms_pkg
// Types and constants shared by the row-major matrix store modules.
// ----------------------------------------------------------------------------
package rmms_pkg;

	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int WORD_W   = 64;
	localparam int CNT_W    = 5;
	localparam int AGU_W    = 10;

	localparam logic [CNT_W-1:0] ROW_LIMIT = CNT_W'(MAX_ROWS);
	localparam logic [CNT_W-1:0] COL_LIMIT = CNT_W'(MAX_COLS);

	typedef enum logic [2:0] {
		ACT_READ   = 3'd0,
		ACT_WRITE  = 3'd1,
		ACT_SWAP   = 3'd2,
		ACT_INSERT = 3'd3,
		ACT_CREATE = 3'd4
	} action_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic REG_INITIAL_ROWS = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic [3:0]        col;
		logic [3:0]        row_b;
		logic [4:0]        row_a;
		logic [2:0]        action;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0]  col_count;
		logic [CNT_W-1:0]  row_count;
		logic [1:0]        status;
		logic [WORD_W-1:0] read_value;
	} result_t;

	typedef struct packed {
		logic              clear_all;
		logic              wen;
		logic [ADDR_W-1:0] waddr;
		logic [WORD_W-1:0] wdata;
		logic              ren;
		logic [ADDR_W-1:0] raddr;
	} store_req_t;

endpackage

/* sv/rmms_agu.sv */
// ----------------------------------------------------------------------------
// rmms_agu
// Shared address unit: row * columns + offset.
// ----------------------------------------------------------------------------
module rmms_agu import rmms_pkg::*; (
	input  logic [CNT_W-1:0] row,
	input  logic [CNT_W-1:0] cols,
	input  logic [CNT_W-1:0] offset,
	output logic [AGU_W-1:0] addr
);

	logic [AGU_W-1:0] prod;

	assign prod = AGU_W'(row) * AGU_W'(cols);
	assign addr = prod + AGU_W'(offset);

endmodule

/* sv/rmms_store.sv */
// ----------------------------------------------------------------------------
// rmms_store
// Element memory with one write and one registered read port, plus a
// valid bit per word so that unwritten or cleared words read as zero.
// ----------------------------------------------------------------------------
module rmms_store import rmms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  store_req_t        req,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [WORD_W-1:0] rd_data_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wen) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.ren) begin
			rd_data_q <= mem_q[req.raddr];
		end
	end

	// A create clears every valid bit at once; the words themselves are left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clear_all) begin
				valid_q <= '0;
			end else if (req.wen) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.ren) begin
				rd_valid_q <= valid_q[req.raddr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_data_q : '0;

endmodule

/* sv/rmms_seq.sv */
// ----------------------------------------------------------------------------
// rmms_seq
// Action sequencer: range checks, row count, and the word-by-word walks
// for swap and insert through the shared address unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmms_seq import rmms_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  item_t             in_item,
	input  logic [CNT_W-1:0]  cols,
	input  logic [CNT_W-1:0]  init_rows,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res,
	output store_req_t        req,
	input  logic [WORD_W-1:0] rdata
);

	typedef enum logic [3:0] {
		S_IDLE, S_OP, S_RWAIT,
		S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
		S_IN_LO, S_IN_DST, S_IN_SRC,
		S_MV_RD, S_MV_WR, S_ZR, S_FIN
	} state_t;

	state_t            state_q;
	logic [2:0]        action_q;
	logic [4:0]        ra_q;
	logic [3:0]        rb_q;
	logic [3:0]        col_q;
	logic [WORD_W-1:0] value_q;
	logic [WORD_W-1:0] rd_value_q;
	logic [1:0]        status_q;
	logic [CNT_W-1:0]  rows_q;
	logic [CNT_W-1:0]  j_q;
	logic [WORD_W-1:0] tmp_q;
	logic [AGU_W-1:0]  lo_q;
	logic [AGU_W-1:0]  dst_q;
	logic [AGU_W-1:0]  src_q;

	logic [CNT_W-1:0]  agu_row;
	logic [CNT_W-1:0]  agu_off;
	logic [AGU_W-1:0]  agu_addr;
	logic [CNT_W-1:0]  j_next;
	logic              ok_rw;
	logic              ok_swap;

	rmms_agu u_agu (
		.row    (agu_row),
		.cols   (cols),
		.offset (agu_off),
		.addr   (agu_addr)
	);

	assign j_next  = j_q + CNT_W'(1);
	assign ok_rw   = (ra_q < rows_q) && (CNT_W'(col_q) < cols);
	assign ok_swap = (ra_q < rows_q) && (CNT_W'(rb_q) < rows_q);

	// Operand selection for the shared address unit.
	always_comb begin
		agu_row = ra_q;
		agu_off = j_q;
		unique case (state_q)
			S_OP: begin
				agu_off = CNT_W'(col_q);
			end
			S_SW_RB, S_SW_WB: begin
				agu_row = CNT_W'(rb_q);
			end
			S_IN_LO: begin
				agu_off = cols;
			end
			S_IN_DST: begin
				agu_row = rows_q;
				agu_off = cols - CNT_W'(1);
			end
			S_IN_SRC: begin
				agu_row = rows_q - CNT_W'(1);
				agu_off = cols - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		req           = '0;
		req.waddr     = agu_addr[ADDR_W-1:0];
		req.raddr     = agu_addr[ADDR_W-1:0];
		req.wdata     = rdata;
		unique case (state_q)
			S_OP: begin
				case (action_q)
					ACT_READ:   req.ren = ok_rw;
					ACT_WRITE: begin
						req.wen   = ok_rw;
						req.wdata = value_q;
					end
					ACT_CREATE: req.clear_all = 1'b1;
					default: begin
					end
				endcase
			end
			S_SW_RA, S_SW_RB: req.ren = 1'b1;
			S_SW_WA: req.wen = 1'b1;
			S_SW_WB: begin
				req.wen   = 1'b1;
				req.wdata = tmp_q;
			end
			S_MV_RD: begin
				req.ren   = 1'b1;
				req.raddr = src_q[ADDR_W-1:0];
			end
			S_MV_WR: begin
				req.wen   = 1'b1;
				req.waddr = dst_q[ADDR_W-1:0];
			end
			S_ZR: begin
				req.wen   = 1'b1;
				req.wdata = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rows_q     <= '0;
			status_q   <= ST_OK;
			rd_value_q <= '0;
			action_q   <= '0;
			ra_q       <= '0;
			rb_q       <= '0;
			col_q      <= '0;
			j_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						action_q <= in_item.action;
						ra_q     <= in_item.row_a;
						rb_q     <= in_item.row_b;
						col_q    <= in_item.col;
						value_q  <= in_item.value;
						state_q  <= S_OP;
					end
				end
				S_OP: begin
					rd_value_q <= '0;
					status_q   <= ST_OK;
					j_q        <= '0;
					state_q    <= S_FIN;
					case (action_q)
						ACT_READ: begin
							if (ok_rw) begin
								state_q <= S_RWAIT;
							end else begin
								status_q <= ST_RANGE;
							end
						end
						ACT_WRITE: begin
							if (!ok_rw) begin
								status_q <= ST_RANGE;
							end
						end
						ACT_SWAP: begin
							if (!ok_swap) begin
								status_q <= ST_RANGE;
							end else if (cols != '0) begin
								state_q <= S_SW_RA;
							end
						end
						ACT_INSERT: begin
							if (ra_q > rows_q) begin
								status_q <= ST_RANGE;
							end else if (rows_q >= ROW_LIMIT) begin
								status_q <= ST_FULL;
							end else if (cols == '0) begin
								rows_q <= rows_q + CNT_W'(1);
							end else begin
								state_q <= S_IN_LO;
							end
						end
						ACT_CREATE: begin
							rows_q <= (init_rows > ROW_LIMIT) ? ROW_LIMIT : init_rows;
						end
						default: begin
						end
					endcase
				end
				S_RWAIT: begin
					rd_value_q <= rdata;
					state_q    <= S_FIN;
				end
				S_SW_RA: state_q <= S_SW_RB;
				S_SW_RB: begin
					tmp_q   <= rdata;
					state_q <= S_SW_WA;
				end
				S_SW_WA: state_q <= S_SW_WB;
				S_SW_WB: begin
					j_q     <= j_next;
					state_q <= (j_next == cols) ? S_FIN : S_SW_RA;
				end
				S_IN_LO: begin
					lo_q    <= agu_addr;
					state_q <= S_IN_DST;
				end
				S_IN_DST: begin
					dst_q   <= agu_addr;
					state_q <= S_IN_SRC;
				end
				S_IN_SRC: begin
					src_q   <= agu_addr;
					state_q <= (rows_q > ra_q) ? S_MV_RD : S_ZR;
				end
				S_MV_RD: state_q <= S_MV_WR;
				S_MV_WR: begin
					dst_q   <= dst_q - AGU_W'(1);
					src_q   <= src_q - AGU_W'(1);
					state_q <= (dst_q > lo_q) ? S_MV_RD : S_ZR;
				end
				S_ZR: begin
					j_q <= j_next;
					if (j_next == cols) begin
						rows_q  <= rows_q + CNT_W'(1);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign res_valid      = (state_q == S_FIN);
	assign res.read_value = rd_value_q;
	assign res.status     = status_q;
	assign res.row_count  = rows_q;
	assign res.col_count  = cols;

	`RMMS_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready)
	`RMMS_ASSERT_NEVER(a_rows_bound, clk, arst_n, rows_q > ROW_LIMIT)
	`RMMS_ASSERT_NEVER(a_one_port_use, clk, arst_n, req.wen && req.ren)
	`RMMS_ASSERT(a_result_held, clk, arst_n, res_valid && !res_ready |=> res_valid)

endmodule

/* sv/row_major_matrix_store.sv */
// ----------------------------------------------------------------------------
// row_major_matrix_store
// Dense 16 x 16 matrix of opaque 64-bit words, kept row-major in one store.
// ----------------------------------------------------------------------------
// Each input word is one action (read, write, swap rows, insert a zeroed row,
// create) and yields exactly one output word with the read value, a status
// and the current row and column counts. The block works on one action at a
// time and drops s_tready until that action's result has been handed to the
// output register. All traffic to the element memory comes from the
// sequencer, which never uses the store's write and read ports together, so
// the memory sets the cost. A write, a create or an undefined action needs
// only the S_OP state, and a create clears the per-word valid bits at
// once; a read also waits for the registered read data; a swap reads and
// writes both rows word by word; and an insert moves every word below the
// insert point by a read and a write, then zeroes the new row. The
// result register is loaded in the cycle before the next word can be taken.
// Reset needs no clearing pass: the valid bits make the whole store
// read as zero at once. A column count above 16 is used as 16, and the
// column register is read on every action; both registers should only be
// written while the block is idle.
// ----------------------------------------------------------------------------
module row_major_matrix_store import rmms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Action words in
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] action, [7:3] row_a, [11:8] row_b, [15:12] col, [79:16] value
	input  logic [79:0] s_tdata,
	// Result words out
	output logic        m_tvalid,
	input  logic        m_tready,
	// [63:0] read_value, [65:64] status, [70:66] row_count,
	// [75:71] col_count, [79:76] zero
	output logic [79:0] m_tdata
);

	logic [CNT_W-1:0] initial_rows_q;
	logic [CNT_W-1:0] column_count_q;
	logic [CNT_W-1:0] cols_eff;
	logic             cfg_write;

	item_t            in_item;
	result_t          res;
	logic             res_valid;
	logic             res_ready;
	store_req_t       req;
	logic [WORD_W-1:0] rdata;

	logic             out_valid_q;
	logic [79:0]      out_data_q;

	// Configuration registers; the low bits of the address are ignored.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_rows_q <= CNT_W'(4);
			column_count_q <= CNT_W'(16);
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_INITIAL_ROWS: initial_rows_q <= pwdata[CNT_W-1:0];
				REG_COLUMN_COUNT: column_count_q <= pwdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_COLUMN_COUNT) ? {27'd0, column_count_q}
	                                               : {27'd0, initial_rows_q};

	// A column count beyond the store width behaves as the store width.
	assign cols_eff = (column_count_q > COL_LIMIT) ? COL_LIMIT : column_count_q;

	assign in_item.action = s_tdata[2:0];
	assign in_item.row_a  = s_tdata[7:3];
	assign in_item.row_b  = s_tdata[11:8];
	assign in_item.col    = s_tdata[15:12];
	assign in_item.value  = s_tdata[79:16];

	rmms_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.cols      (cols_eff),
		.init_rows (initial_rows_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.req       (req),
		.rdata     (rdata)
	);

	rmms_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	// Output register: the sequencer may hand over a new result whenever the
	// register is empty or its word is taken in the same cycle.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= {4'd0, res.col_count, res.row_count, res.status, res.read_value};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Testbench for row_major_matrix_store
// Drives action words into the matrix store and checks every result word.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the matrix, the row count and both
// registers. Each action word that the block accepts is run through that
// copy, and the outcome is queued. Result words are compared field by field
// with the oldest queued outcome. A short scripted sequence walks the
// corner cases first: reads before any create, out-of-range indices, swaps,
// inserts up to a full store, saturating registers, zero columns, and
// undefined actions. Several register settings with random traffic follow.
// Both stream sides stall at random, except during one settings phase that
// runs without stalls.
// ----------------------------------------------------------------------------
module testbench;
	import rmms_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Action codes 5 to 7 have no meaning, and the block must ignore them.
	localparam logic [2:0] ACT_RSVD_5 = 3'd5;
	localparam logic [2:0] ACT_RSVD_6 = 3'd6;
	localparam logic [2:0] ACT_RSVD_7 = 3'd7;

	localparam int RANDOM_PHASES  = 7;
	localparam int WORDS_PER_PHASE = 70;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	// [2:0] action, [7:3] row_a, [11:8] row_b, [15:12] col, [79:16] value
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [63:0] read_value, [65:64] status, [70:66] row_count,
	// [75:71] col_count, [79:76] zero
	logic [79:0] m_tdata;

	row_major_matrix_store i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Shadow of the block: the flat word store, the rows in use and both
	// registers, as they stand after every accepted action word.
	logic [WORD_W-1:0] shadow_words [DEPTH];
	int                rows_held;
	logic [CNT_W-1:0]  shadow_initial_rows;
	logic [CNT_W-1:0]  shadow_columns;

	// Outcomes of accepted action words, oldest first.
	result_t expected_results [$];

	// One row of the scripted sequence: either a register write, or an
	// action word with an optional hand-written expected result.
	typedef struct {
		bit      is_reg;
		logic    reg_sel;
		logic [CNT_W-1:0] reg_value;
		item_t   word;
		bit      typed;
		result_t want;
	} script_row_t;

	script_row_t script [$];

	bit steady;
	int fail_count;
	int action_tally [8];
	int status_tally [4];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A column count above the matrix width is used as the matrix width.
	function automatic int active_cols();
		return (shadow_columns > COL_LIMIT) ? MAX_COLS : int'(shadow_columns);
	endfunction

	// Applies one action word to the shadow matrix and returns the result
	// word that the block must produce for it.
	function automatic result_t apply_action(item_t w);
		int cols;
		int ra;
		int rb;
		int c;
		int idx;
		int lo;
		logic [WORD_W-1:0] held;
		result_t r;
		cols = active_cols();
		ra = w.row_a;
		rb = w.row_b;
		c = w.col;
		r = '0;
		r.status = ST_OK;
		case (w.action)
			ACT_READ: begin
				if (ra < rows_held && c < cols) r.read_value = shadow_words[ra * cols + c];
				else r.status = ST_RANGE;
			end
			ACT_WRITE: begin
				// An out-of-range write is dropped entirely.
				if (ra < rows_held && c < cols) shadow_words[ra * cols + c] = w.value;
				else r.status = ST_RANGE;
			end
			ACT_SWAP: begin
				if (ra < rows_held && rb < rows_held) begin
					for (int j = 0; j < cols; j++) begin
						held = shadow_words[ra * cols + j];
						shadow_words[ra * cols + j] = shadow_words[rb * cols + j];
						shadow_words[rb * cols + j] = held;
					end
				end else begin
					r.status = ST_RANGE;
				end
			end
			ACT_INSERT: begin
				// The position check wins over the full check.
				if (ra > rows_held) begin
					r.status = ST_RANGE;
				end else if (rows_held >= MAX_ROWS) begin
					r.status = ST_FULL;
				end else begin
					idx = (rows_held + 1) * cols;
					lo = (ra + 1) * cols;
					while (idx > lo) begin
						idx--;
						shadow_words[idx] = shadow_words[idx - cols];
					end
					for (int j = 0; j < cols; j++) shadow_words[ra * cols + j] = '0;
					rows_held++;
				end
			end
			ACT_CREATE: begin
				foreach (shadow_words[k]) shadow_words[k] = '0;
				rows_held = (shadow_initial_rows > ROW_LIMIT) ? MAX_ROWS
					: int'(shadow_initial_rows);
			end
			default: begin
			end
		endcase
		r.row_count = CNT_W'(rows_held);
		r.col_count = CNT_W'(cols);
		return r;
	endfunction

	// Random action word. Most words are well formed against the current
	// shape of the matrix, so that writes land where later reads, swaps and
	// inserts find them; a small share is raw noise over every field.
	function automatic item_t random_word();
		item_t w;
		int cols;
		int pick;
		cols = active_cols();
		pick = $urandom_range(99);
		w.value = {$urandom, $urandom};
		if ($urandom_range(7) == 0) w.value = $urandom_range(1) ? '1 : '0;
		w.row_a = (rows_held > 0) ? 5'($urandom_range(rows_held - 1)) : 5'd0;
		w.row_b = (rows_held > 0) ? 4'($urandom_range(rows_held - 1)) : 4'd0;
		w.col = (cols > 0) ? 4'($urandom_range(cols - 1)) : 4'($urandom);
		if (pick < 32) begin
			w.action = ACT_READ;
		end else if (pick < 64) begin
			w.action = ACT_WRITE;
		end else if (pick < 76) begin
			w.action = ACT_SWAP;
		end else if (pick < 88) begin
			// Any position up to and including an append.
			w.action = ACT_INSERT;
			w.row_a = 5'($urandom_range(rows_held));
		end else if (pick < 91) begin
			w.action = ACT_CREATE;
		end else begin
			w.action = 3'($urandom);
			w.row_a = 5'($urandom);
			w.row_b = 4'($urandom);
			w.col = 4'($urandom);
		end
		return w;
	endfunction

	function automatic void add_reg(logic sel, logic [CNT_W-1:0] value);
		script_row_t s;
		s = '{default: '0};
		s.is_reg = 1'b1;
		s.reg_sel = sel;
		s.reg_value = value;
		script.push_back(s);
	endfunction

	function automatic void add_word(logic [2:0] action, logic [4:0] ra, logic [3:0] rb,
			logic [3:0] c, logic [WORD_W-1:0] value);
		script_row_t s;
		s = '{default: '0};
		s.word = '{value: value, col: c, row_b: rb, row_a: ra, action: action};
		script.push_back(s);
	endfunction

	// Same as add_word, with the result written out by hand. Every such row
	// expects a zero read value.
	function automatic void add_checked(logic [2:0] action, logic [4:0] ra, logic [3:0] rb,
			logic [3:0] c, logic [WORD_W-1:0] value, logic [1:0] status,
			logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
		add_word(action, ra, rb, c, value);
		script[$].typed = 1'b1;
		script[$].want = '{col_count: cols, row_count: rows, status: status,
			read_value: '0};
	endfunction

	task automatic write_reg(logic sel, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (sel == REG_INITIAL_ROWS) shadow_initial_rows = data[CNT_W-1:0];
		else shadow_columns = data[CNT_W-1:0];
	endtask

	// Offers one action word, with random idle cycles ahead of it, and
	// queues its outcome once the block takes it.
	task automatic send_word(item_t w, bit typed, result_t want);
		result_t predicted;
		while (!steady && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		predicted = apply_action(w);
		expected_results.push_back(typed ? want : predicted);
		action_tally[w.action]++;
	endtask

	// Holds the sender off until every queued result has come back. Every
	// action yields exactly one result word, and the block is idle once that
	// word has gone out.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic compare_field(string field, logic [WORD_W-1:0] want,
			logic [WORD_W-1:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s mismatch, expected 'h%0h, got 'h%0h",
				$time, field, want, got);
		end
	endtask

	// The receiver stalls at random, and each accepted result word is checked
	// against the oldest queued outcome.
	result_t seen;
	result_t oldest;

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 30);
		if (arst_n && m_tvalid && m_tready) begin
			seen = m_tdata[75:0];
			if (seen.status < 4) status_tally[seen.status]++;
			if (expected_results.size() == 0) begin
				fail_count++;
				$display("%0t ns: result word with nothing expected, expected none, got 'h%0h",
					$time, m_tdata);
			end else begin
				oldest = expected_results.pop_front();
				compare_field("read_value", oldest.read_value, seen.read_value);
				compare_field("status", oldest.status, seen.status);
				compare_field("row_count", oldest.row_count, seen.row_count);
				compare_field("col_count", oldest.col_count, seen.col_count);
				compare_field("padding", '0, m_tdata[79:76]);
			end
		end
	end

	initial begin
		int rows_cfg;
		int cols_cfg;
		item_t w;
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		steady   = 1'b0;
		fail_count = 0;
		foreach (shadow_words[k]) shadow_words[k] = '0;
		rows_held = 0;
		shadow_initial_rows = 5'd4;
		shadow_columns = 5'd16;

		// Out of reset the matrix has no rows, so every index is out of
		// range, including an insert past row zero.
		add_checked(ACT_READ, 5'd0, 4'd0, 4'd0, '0, ST_RANGE, 5'd0, 5'd16);
		add_checked(ACT_INSERT, 5'd1, 4'd0, 4'd0, '0, ST_RANGE, 5'd0, 5'd16);
		add_checked(ACT_CREATE, 5'd0, 4'd0, 4'd0, '0, ST_OK, 5'd4, 5'd16);
		// Corner words at corner cells, then moved around by swaps and inserts.
		add_word(ACT_WRITE, 5'd0, 4'd0, 4'd0, '1);
		add_word(ACT_WRITE, 5'd3, 4'd0, 4'd15, 64'h8000_0000_0000_0001);
		add_word(ACT_READ, 5'd3, 4'd0, 4'd15, '0);
		add_checked(ACT_READ, 5'd4, 4'd0, 4'd0, '0, ST_RANGE, 5'd4, 5'd16);
		add_checked(ACT_WRITE, 5'd31, 4'd0, 4'd15, '1, ST_RANGE, 5'd4, 5'd16);
		add_word(ACT_SWAP, 5'd0, 4'd3, 4'd0, '0);
		add_word(ACT_SWAP, 5'd2, 4'd2, 4'd0, '0);
		add_checked(ACT_SWAP, 5'd1, 4'd15, 4'd0, '0, ST_RANGE, 5'd4, 5'd16);
		add_word(ACT_INSERT, 5'd0, 4'd0, 4'd0, '0);
		add_word(ACT_INSERT, 5'd5, 4'd0, 4'd0, '0);
		add_checked(ACT_INSERT, 5'd31, 4'd0, 4'd0, '0, ST_RANGE, 5'd6, 5'd16);
		add_word(ACT_READ, 5'd1, 4'd0, 4'd0, '0);
		add_word(ACT_READ, 5'd4, 4'd0, 4'd15, '0);
		add_checked(ACT_RSVD_7, 5'd31, 4'd15, 4'd15, '1, ST_OK, 5'd6, 5'd16);
		// Both registers above their limits saturate to a full 16 x 16 store,
		// which refuses an insert, unless the position is already too far.
		add_reg(REG_INITIAL_ROWS, 5'd31);
		add_reg(REG_COLUMN_COUNT, 5'd31);
		add_checked(ACT_CREATE, 5'd0, 4'd0, 4'd0, '0, ST_OK, 5'd16, 5'd16);
		add_checked(ACT_INSERT, 5'd0, 4'd0, 4'd0, '0, ST_FULL, 5'd16, 5'd16);
		add_checked(ACT_INSERT, 5'd17, 4'd0, 4'd0, '0, ST_RANGE, 5'd16, 5'd16);
		// With zero columns no element exists, yet an insert still adds a row.
		add_reg(REG_COLUMN_COUNT, 5'd0);
		add_reg(REG_INITIAL_ROWS, 5'd0);
		add_checked(ACT_CREATE, 5'd0, 4'd0, 4'd0, '0, ST_OK, 5'd0, 5'd0);
		add_checked(ACT_READ, 5'd0, 4'd0, 4'd0, '0, ST_RANGE, 5'd0, 5'd0);
		add_checked(ACT_INSERT, 5'd0, 4'd0, 4'd0, '0, ST_OK, 5'd1, 5'd0);
		add_checked(ACT_WRITE, 5'd0, 4'd0, 4'd0, '1, ST_RANGE, 5'd1, 5'd0);
		add_checked(ACT_RSVD_5, 5'd0, 4'd0, 4'd0, '0, ST_OK, 5'd1, 5'd0);
		add_checked(ACT_RSVD_6, 5'd0, 4'd0, 4'd0, '0, ST_OK, 5'd1, 5'd0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register writes wait until the block has handed back every result.
		foreach (script[i]) begin
			if (script[i].is_reg) begin
				wait_idle();
				write_reg(script[i].reg_sel, 32'(script[i].reg_value));
			end else begin
				send_word(script[i].word, script[i].typed, script[i].want);
			end
		end

		// Random traffic under a series of register settings. Each phase
		// starts from an idle block. One phase runs with no stalls on either
		// side, and one keeps the old contents under a new column count, so
		// the stored words are read with a different row stride.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			steady = (p == 1);
			case (p)
				0: begin rows_cfg = 16; cols_cfg = 16; end
				1: begin rows_cfg = 4; cols_cfg = 16; end
				2: begin rows_cfg = $urandom_range(31); cols_cfg = $urandom_range(16, 1); end
				3: begin rows_cfg = 31; cols_cfg = 31; end
				4: begin rows_cfg = 8; cols_cfg = 1; end
				5: begin rows_cfg = 0; cols_cfg = 16; end
				default: begin
					rows_cfg = $urandom_range(31);
					cols_cfg = $urandom_range(31);
				end
			endcase
			// The upper bits of the written word carry noise that must not
			// reach either register.
			write_reg(REG_COLUMN_COUNT, {27'($urandom), 5'(cols_cfg)});
			write_reg(REG_INITIAL_ROWS, {27'($urandom), 5'(rows_cfg)});
			if (p != 3) begin
				w = random_word();
				w.action = ACT_CREATE;
				send_word(w, 1'b0, '0);
			end
			repeat (WORDS_PER_PHASE) send_word(random_word(), 1'b0, '0);
		end
		steady = 1'b0;

		wait_idle();
		repeat (40) @(posedge clk);

		$display("Sent %0d reads, %0d writes, %0d swaps, %0d inserts, %0d creates, %0d others.",
			action_tally[ACT_READ], action_tally[ACT_WRITE], action_tally[ACT_SWAP],
			action_tally[ACT_INSERT], action_tally[ACT_CREATE],
			action_tally[ACT_RSVD_5] + action_tally[ACT_RSVD_6] + action_tally[ACT_RSVD_7]);
		$display("Status seen: %0d ok, %0d out of range, %0d full, over %0d settings.",
			status_tally[ST_OK], status_tally[ST_RANGE], status_tally[ST_FULL],
			RANDOM_PHASES + 3);
		if (fail_count == 0) begin
			$display("** row_major_matrix_store: PASSED **");
		end else begin
			$display("** row_major_matrix_store: FAILED **");
		end
		$finish;
	end

	// Even with every word taking the longest insert and every stall, the
	// run stays well inside this bound.
	initial begin
		#(20ms);
		$display("Timed out with %0d results still outstanding.", expected_results.size());
		$display("** row_major_matrix_store: FAILED **");
		$finish;
	end

endmodule
